// ----- rtl/pstab_pkg.sv -----
// ----------------------------------------------------------------------------
// pstab_pkg
// shared types, constants and the cordic arctangent table for the pitch
// stabiliser
// ----------------------------------------------------------------------------
package pstab_pkg;

   // angle and time fixed point
   localparam int ANGLE_FRAC = 8;
   localparam int TAB_FRAC   = 16;
   localparam int TIME_FRAC  = 16;
   localparam int GAIN_FRAC  = 8;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TAB_LEN          = 24;
   localparam int TAB_IDX_W        = 5;
   localparam int SQRT_STEPS       = 24;

   localparam logic [16:0] FULL_ANGLE  = 17'(180 << ANGLE_FRAC);
   localparam logic [15:0] OFFSET_90   = 16'(90 << ANGLE_FRAC);
   localparam logic [15:0] SERVO_RESET = 16'd23040;
   localparam longint      INTEG_LIM   = longint'(200) << (ANGLE_FRAC + TIME_FRAC);
   localparam longint      CORR_LIM    = longint'(85) << (ANGLE_FRAC + GAIN_FRAC);

   // configuration register indexes
   localparam logic [2:0] CFG_MIN_ANGLE     = 3'd0;
   localparam logic [2:0] CFG_MAX_ANGLE     = 3'd1;
   localparam logic [2:0] CFG_PITCH_COMMAND = 3'd2;
   localparam logic [2:0] CFG_FILTER_TAU    = 3'd3;
   localparam logic [2:0] CFG_GAIN_P        = 3'd4;
   localparam logic [2:0] CFG_GAIN_I        = 3'd5;
   localparam logic [2:0] CFG_GAIN_D        = 3'd6;
   localparam logic [2:0] CFG_MAX_STEP      = 3'd7;

   // divider geometry
   localparam int DIV_NUM_W = 54;
   localparam int DIV_DEN_W = 33;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [21:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/pstab_div.sv -----
// ----------------------------------------------------------------------------
// pstab_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pstab_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pstab_pkg::div_req_type req,
   output pstab_pkg::div_rsp_type rsp
);
   import pstab_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] quo_ff;

   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign rem_sub = {1'b0, rem_sh} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.num;
         den_ff <= req.den;
      end else if (busy_ff) begin
         if (!rem_sub[DIV_DEN_W+1]) begin
            rem_ff <= rem_sub[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ----- rtl/pitch_stabilizer_pid.sv -----
// ----------------------------------------------------------------------------
// pitch_stabilizer_pid
// one pitch axis of a servo gimbal: accelerometer pitch by square root and
// cordic, complementary filter, pid with anti-windup, slew and limit clamps
// ----------------------------------------------------------------------------
// One word in, one word out. The input is stalled from acceptance until the
// result is written to the output register, so a new word is taken only once
// the last one is through. The processing time is set by the shared divider,
// used twice (the filter blend and the derivative term), the 24-step square
// root and one cordic step per cycle; the multiplies share one 38x18
// multiplier.
// A finished result waits in the output register while the next word starts.
module pitch_stabilizer_pid #(
   parameter int CORDIC_STEPS = pstab_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [19:0] req_gyro_pitch_rate,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_servo_angle,
   output logic signed [16:0] rsp_filtered_pitch,
   output logic signed [15:0] rsp_correction,
   output logic               rsp_integral_frozen
);
   import pstab_pkg::*;

   localparam logic [TAB_IDX_W-1:0] CORDIC_LAST = TAB_IDX_W'(CORDIC_STEPS - 1);
   localparam logic [TAB_IDX_W-1:0] SQRT_LAST   = TAB_IDX_W'(SQRT_STEPS - 1);
   localparam int                   ROUND_SH    = TAB_FRAC - ANGLE_FRAC;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ_Y, S_SQ_Z, S_SQRT_INIT, S_SQRT, S_CORDIC_INIT, S_CORDIC,
      S_ACC, S_FILT_A, S_FILT_B, S_FILT_C, S_FILT_DIV, S_ERR, S_MUL_EDT,
      S_INTEG, S_MUL_I, S_MUL_D, S_D_START, S_D_DIV, S_CORR, S_POS, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0]        min_angle_ff, max_angle_ff, pitch_command_ff, filter_tau_ff;
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [15:0]        max_step_ff;

   // captured word
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [19:0] gyro_ff;
   logic [15:0]        dt_ff;

   // working registers
   logic signed [55:0]       prod_ff;
   logic [31:0]              sumsq_ff;
   logic [47:0]              rad_ff;
   logic [23:0]              root_ff;
   logic [25:0]              srem_ff;
   logic signed [27:0]       cx_ff, cy_ff;
   logic signed [24:0]       cz_ff;
   logic                     zero_ff;
   logic [TAB_IDX_W-1:0]     cnt_ff;
   logic signed [15:0]       acc_ff;
   logic signed [37:0]       fsum_ff;
   logic signed [55:0]       accterm_ff;
   logic                     sign_ff;
   logic signed [17:0]       err_ff;
   logic signed [18:0]       diff_ff;
   logic                     frozen_ff;
   logic signed [51:0]       psum_ff;
   logic signed [15:0]       corr_ff;
   logic [15:0]              pos_ff;

   // controller state
   logic signed [16:0] pe_ff;
   logic signed [17:0] prev_ff;
   logic signed [33:0] integ_ff;
   logic [15:0]        cur_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_servo_ff;
   logic signed [16:0] rsp_pitch_ff;
   logic signed [15:0] rsp_corr_ff;
   logic               rsp_frozen_ff;

   // shared multiplier
   logic signed [37:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [55:0] mul_p;

   always_comb begin
      case (state_ff)
         S_SQ_Y: begin
            mul_a = 38'(ay_ff);
            mul_b = 18'(ay_ff);
         end
         S_SQ_Z: begin
            mul_a = 38'(az_ff);
            mul_b = 18'(az_ff);
         end
         S_ACC: begin
            mul_a = 38'(gyro_ff);
            mul_b = $signed({2'b00, dt_ff});
         end
         S_FILT_A: begin
            mul_a = 38'(acc_ff);
            mul_b = $signed({2'b00, dt_ff});
         end
         S_FILT_B: begin
            mul_a = fsum_ff;
            mul_b = $signed({2'b00, filter_tau_ff});
         end
         S_MUL_EDT: begin
            mul_a = 38'(err_ff);
            mul_b = $signed({2'b00, dt_ff});
         end
         S_INTEG: begin
            mul_a = 38'(err_ff);
            mul_b = 18'(gain_p_ff);
         end
         S_MUL_I: begin
            mul_a = 38'(integ_ff);
            mul_b = 18'(gain_i_ff);
         end
         S_MUL_D: begin
            mul_a = 38'(diff_ff);
            mul_b = 18'(gain_d_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // square root step, two radicand bits a cycle
   logic [27:0] sq_sh, sq_trial, sq_diff;
   logic        sq_ge;
   assign sq_sh    = {srem_ff, rad_ff[47:46]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_sh >= sq_trial);
   assign sq_diff  = sq_sh - sq_trial;

   // cordic vectoring step
   logic signed [27:0] cx_sh, cy_sh;
   logic signed [24:0] atan_val;
   assign cx_sh    = cx_ff >>> cnt_ff;
   assign cy_sh    = cy_ff >>> cnt_ff;
   assign atan_val = $signed({3'b000, atan_entry(cnt_ff)});

   // accelerometer pitch rounded to angle units
   logic [24:0]        cz_mag;
   logic [24:0]        cz_rnd;
   logic signed [15:0] acc_in;
   assign cz_mag = cz_ff[24] ? 25'(-cz_ff) : 25'(cz_ff);
   assign cz_rnd = (cz_mag + 25'(1 << (ROUND_SH - 1))) >> ROUND_SH;
   assign acc_in = zero_ff ? 16'sd0 : (cz_ff[24] ? -$signed(cz_rnd[15:0])
                                                 : $signed(cz_rnd[15:0]));

   // filter blend operands
   logic signed [55:0] num_in;
   logic [55:0]        num_mag;
   logic [16:0]        tausum;
   assign num_in  = prod_ff + accterm_ff;
   assign num_mag = num_in[55] ? 56'(-num_in) : 56'(num_in);
   assign tausum  = {1'b0, filter_tau_ff} + {1'b0, dt_ff};

   // derivative operands
   logic signed [55:0] dnum;
   logic [55:0]        dnum_mag;
   assign dnum     = prod_ff <<< TIME_FRAC;
   assign dnum_mag = dnum[55] ? 56'(-dnum) : 56'(dnum);

   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         S_FILT_C: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(num_mag) + DIV_NUM_W'({tausum, 15'd0});
            div_req.den   = {tausum, 16'd0};
         end
         S_D_START: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(dnum_mag) + DIV_NUM_W'(dt_ff >> 1);
            div_req.den   = DIV_DEN_W'(dt_ff);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   pstab_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // filtered estimate, saturated
   logic [16:0]        est_mag;
   logic signed [16:0] est_in;
   assign est_mag = (div_rsp.quo > DIV_NUM_W'(FULL_ANGLE)) ? FULL_ANGLE
                                                            : div_rsp.quo[16:0];
   assign est_in  = sign_ff ? -$signed(est_mag) : $signed(est_mag);

   // error against clamped command
   logic [15:0]        tgt_lo, tgt_c;
   logic signed [18:0] err_w;
   logic signed [17:0] err_in;
   logic               frozen_in;
   logic signed [18:0] diff_in;
   assign tgt_lo    = (pitch_command_ff < min_angle_ff) ? min_angle_ff : pitch_command_ff;
   assign tgt_c     = (tgt_lo > max_angle_ff) ? max_angle_ff : tgt_lo;
   assign err_w     = 19'(pe_ff) - $signed({3'b000, tgt_c}) + $signed({3'b000, OFFSET_90});
   assign err_in    = err_w[17:0];
   assign frozen_in = ((cur_ff >= max_angle_ff) && !err_in[17] && (err_in != '0)) ||
                      ((cur_ff <= min_angle_ff) && err_in[17]);
   assign diff_in   = 19'(err_in) - 19'(prev_ff);

   // integral with clamp
   logic signed [35:0] isum;
   logic signed [35:0] integ_in;
   assign isum = 36'(integ_ff) + 36'(prod_ff);
   always_comb begin
      integ_in = isum;
      if (isum < -36'(INTEG_LIM))
         integ_in = -36'(INTEG_LIM);
      if (integ_in > 36'(INTEG_LIM))
         integ_in = 36'(INTEG_LIM);
   end

   // integral term rounding
   logic [55:0]        ip_mag, ip_rnd;
   logic signed [51:0] iterm;
   assign ip_mag = prod_ff[55] ? 56'(-prod_ff) : 56'(prod_ff);
   assign ip_rnd = (ip_mag + 56'(1 << (TIME_FRAC - 1))) >> TIME_FRAC;
   assign iterm  = prod_ff[55] ? -$signed(ip_rnd[51:0]) : $signed(ip_rnd[51:0]);

   logic signed [51:0] dterm;
   assign dterm = sign_ff ? -$signed(div_rsp.quo[51:0]) : $signed(div_rsp.quo[51:0]);

   // correction clamp and round
   logic signed [51:0] pc;
   logic [51:0]        pc_mag, pc_rnd;
   logic signed [15:0] corr_in;
   always_comb begin
      pc = psum_ff;
      if (pc < -52'(CORR_LIM))
         pc = -52'(CORR_LIM);
      if (pc > 52'(CORR_LIM))
         pc = 52'(CORR_LIM);
   end
   assign pc_mag  = pc[51] ? 52'(-pc) : 52'(pc);
   assign pc_rnd  = (pc_mag + 52'(1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
   assign corr_in = pc[51] ? -$signed(pc_rnd[15:0]) : $signed(pc_rnd[15:0]);

   // servo position: midpoint plus correction, slew then limit
   logic [16:0]        mid;
   logic signed [18:0] lo_s, hi_s, step_lo, step_hi, p0, p1, p2, p3;
   assign mid     = 17'(({1'b0, min_angle_ff} + {1'b0, max_angle_ff}) >> 1);
   assign lo_s    = $signed({3'b000, min_angle_ff});
   assign hi_s    = $signed({3'b000, max_angle_ff});
   assign step_lo = $signed({3'b000, cur_ff}) - $signed({3'b000, max_step_ff});
   assign step_hi = $signed({3'b000, cur_ff}) + $signed({3'b000, max_step_ff});
   assign p0      = $signed({2'b00, mid}) + 19'(corr_ff);
   assign p1      = (p0 < step_lo) ? step_lo : p0;
   assign p2      = (p1 > step_hi) ? step_hi : p1;
   assign p3      = (((p2 < lo_s) ? lo_s : p2) > hi_s) ? hi_s : ((p2 < lo_s) ? lo_s : p2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         min_angle_ff     <= 16'd0;
         max_angle_ff     <= FULL_ANGLE[15:0];
         pitch_command_ff <= 16'd23040;
         filter_tau_ff    <= 16'd6554;
         gain_p_ff        <= 16'sd256;
         gain_i_ff        <= 16'sd0;
         gain_d_ff        <= 16'sd0;
         max_step_ff      <= 16'd1280;
         pe_ff            <= '0;
         prev_ff          <= '0;
         integ_ff         <= '0;
         cur_ff           <= SERVO_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CFG_MIN_ANGLE:     min_angle_ff     <= csr_wdata;
               CFG_MAX_ANGLE:     max_angle_ff     <= csr_wdata;
               CFG_PITCH_COMMAND: pitch_command_ff <= csr_wdata;
               CFG_FILTER_TAU:    filter_tau_ff    <= csr_wdata;
               CFG_GAIN_P:        gain_p_ff        <= csr_wdata;
               CFG_GAIN_I:        gain_i_ff        <= csr_wdata;
               CFG_GAIN_D:        gain_d_ff        <= csr_wdata;
               CFG_MAX_STEP:      max_step_ff      <= csr_wdata;
               default: ;
            endcase
         end

         if (!rsp_stall && (state_ff != S_OUT))
            rsp_valid_ff <= 1'b0;

         prod_ff <= mul_p;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff   <= req_accel_x;
                  ay_ff   <= req_accel_y;
                  az_ff   <= req_accel_z;
                  gyro_ff <= req_gyro_pitch_rate;
                  // zero time step counts as one
                  dt_ff    <= (req_time_step == 16'd0) ? 16'd1 : req_time_step;
                  state_ff <= S_SQ_Y;
               end
            end
            S_SQ_Y: state_ff <= S_SQ_Z;
            S_SQ_Z: begin
               sumsq_ff <= prod_ff[31:0];
               state_ff <= S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
               rad_ff   <= {sumsq_ff + prod_ff[31:0], 16'd0};
               srem_ff  <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               rad_ff <= {rad_ff[45:0], 2'b00};
               if (sq_ge) begin
                  srem_ff <= sq_diff[25:0];
                  root_ff <= {root_ff[22:0], 1'b1};
               end else begin
                  srem_ff <= sq_sh[25:0];
                  root_ff <= {root_ff[22:0], 1'b0};
               end
               if (cnt_ff == SQRT_LAST)
                  state_ff <= S_CORDIC_INIT;
               else
                  cnt_ff <= cnt_ff + 1'b1;
            end
            S_CORDIC_INIT: begin
               cx_ff    <= $signed({4'b0000, root_ff});
               cy_ff    <= 28'(ax_ff) <<< 8;
               cz_ff    <= '0;
               zero_ff  <= (root_ff == '0) && (ax_ff == '0);
               cnt_ff   <= '0;
               state_ff <= S_CORDIC;
            end
            S_CORDIC: begin
               if (!cy_ff[27]) begin
                  cx_ff <= cx_ff + cy_sh;
                  cy_ff <= cy_ff - cx_sh;
                  cz_ff <= cz_ff + atan_val;
               end else begin
                  cx_ff <= cx_ff - cy_sh;
                  cy_ff <= cy_ff + cx_sh;
                  cz_ff <= cz_ff - atan_val;
               end
               if (cnt_ff == CORDIC_LAST)
                  state_ff <= S_ACC;
               else
                  cnt_ff <= cnt_ff + 1'b1;
            end
            S_ACC: begin
               acc_ff   <= acc_in;
               state_ff <= S_FILT_A;
            end
            S_FILT_A: begin
               fsum_ff  <= (38'(pe_ff) <<< TIME_FRAC) + 38'(prod_ff);
               state_ff <= S_FILT_B;
            end
            S_FILT_B: begin
               accterm_ff <= prod_ff <<< TIME_FRAC;
               state_ff   <= S_FILT_C;
            end
            S_FILT_C: begin
               sign_ff  <= num_in[55];
               state_ff <= S_FILT_DIV;
            end
            S_FILT_DIV: begin
               if (div_rsp.done) begin
                  pe_ff    <= est_in;
                  state_ff <= S_ERR;
               end
            end
            S_ERR: begin
               err_ff    <= err_in;
               frozen_ff <= frozen_in;
               diff_ff   <= diff_in;
               prev_ff   <= err_in;
               state_ff  <= S_MUL_EDT;
            end
            S_MUL_EDT: state_ff <= S_INTEG;
            S_INTEG: begin
               // anti-windup: hold the integral at a limit pushed outward
               if (!frozen_ff)
                  integ_ff <= 34'(integ_in);
               state_ff <= S_MUL_I;
            end
            S_MUL_I: begin
               psum_ff  <= 52'(prod_ff);
               state_ff <= S_MUL_D;
            end
            S_MUL_D: begin
               psum_ff  <= psum_ff + iterm;
               state_ff <= S_D_START;
            end
            S_D_START: begin
               sign_ff  <= dnum[55];
               state_ff <= S_D_DIV;
            end
            S_D_DIV: begin
               if (div_rsp.done) begin
                  psum_ff  <= psum_ff + dterm;
                  state_ff <= S_CORR;
               end
            end
            S_CORR: begin
               corr_ff  <= corr_in;
               state_ff <= S_POS;
            end
            S_POS: begin
               pos_ff   <= p3[15:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_servo_ff  <= pos_ff;
                  rsp_pitch_ff  <= pe_ff;
                  rsp_corr_ff   <= corr_ff;
                  rsp_frozen_ff <= frozen_ff;
                  cur_ff        <= pos_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_servo_angle     = rsp_servo_ff;
   assign rsp_filtered_pitch  = rsp_pitch_ff;
   assign rsp_correction      = rsp_corr_ff;
   assign rsp_integral_frozen = rsp_frozen_ff;

`ifndef NO_ASSERTIONS
   a_integ_bound : assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= 34'(INTEG_LIM)) && (integ_ff >= -34'(INTEG_LIM)))
      else $error("integral outside its clamp");

   a_pitch_bound : assert property (@(posedge clock) disable iff (reset)
      (pe_ff <= $signed(FULL_ANGLE)) && (pe_ff >= -$signed(FULL_ANGLE)))
      else $error("pitch estimate outside +-180 degrees");

   a_corr_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_correction <= 16'sd21760) && (rsp_correction >= -16'sd21760))
      else $error("correction outside +-85 degrees");

   a_div_done : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_FILT_DIV) || (state_ff == S_D_DIV))
      else $error("divider finished outside a divide wait");
`endif

endmodule
